// ----- rtl/rgvd_pkg.sv -----
`default_nettype none
// ---------------------------------------------------------------------------
// rgvd_pkg
// Types, constants and helpers shared by the range gate voxel filter.
// ---------------------------------------------------------------------------
package rgvd_pkg;

    localparam int COORD_W    = 20;
    localparam int TAG_W      = 16;
    localparam int RANGE_W    = 19;
    localparam int LEAF_W     = 16;
    localparam int LIMIT_W    = 13;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 19;

    localparam int MAX_POINTS = 4096;
    localparam int HASH_W     = 13;
    localparam int HASH_SLOTS = 2 ** HASH_W;
    localparam int KEY_W      = 3 * COORD_W;
    localparam int EPOCH_W    = 8;
    localparam int STEP_W     = 5;
    localparam int DIV_STEPS  = COORD_W;
    localparam int SQ_W       = 2 * COORD_W - 1;
    localparam int R2_W       = SQ_W + 2;
    localparam int RSQ_W      = 2 * RANGE_W;

    localparam logic [31:0] HASH_KX = 32'd73856093;
    localparam logic [31:0] HASH_KY = 32'd19349663;
    localparam logic [31:0] HASH_KZ = 32'd83492791;

    localparam logic [EPOCH_W-1:0] EPOCH_EMPTY = '0;
    localparam logic [EPOCH_W-1:0] EPOCH_FIRST = EPOCH_W'(1);
    localparam logic [EPOCH_W-1:0] EPOCH_LAST  = '1;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_MIN_RANGE = 3'd0,
        REG_MAX_RANGE = 3'd1,
        REG_BLIND     = 3'd2,
        REG_LEAF      = 3'd3,
        REG_MAX_PTS   = 3'd4
    } cfg_reg_t;

    typedef struct packed {
        logic                      scan_start;
        logic signed [COORD_W-1:0] x_mm;
        logic signed [COORD_W-1:0] y_mm;
        logic signed [COORD_W-1:0] z_mm;
        logic [TAG_W-1:0]          time_tag;
    } in_item_t;

    typedef struct packed {
        logic signed [COORD_W-1:0] out_x_mm;
        logic signed [COORD_W-1:0] out_y_mm;
        logic signed [COORD_W-1:0] out_z_mm;
        logic [TAG_W-1:0]          out_time_tag;
    } out_item_t;

    typedef struct packed {
        logic              load;
        logic              step;
        logic [STEP_W-1:0] step_idx;
        logic              probe_init;
        logic              probe_adv;
        logic              rd;
        logic              ins;
        logic              clr_wr;
        logic [HASH_W-1:0] clr_addr;
        logic              emit;
    } rgvd_cmd_t;

    typedef struct packed {
        logic scan_start;
        logic epoch_wrap;
        logic keep_ok;
        logic leaf_zero;
        logic slot_hit;
        logic slot_empty;
        logic out_busy;
    } rgvd_sts_t;

    function automatic logic [HASH_W-1:0] slot_hash(input logic [KEY_W-1:0] key);
        logic [HASH_W-1:0] hx;
        logic [HASH_W-1:0] hy;
        logic [HASH_W-1:0] hz;
        hx = HASH_W'(key[HASH_W-1:0] * HASH_KX[HASH_W-1:0]);
        hy = HASH_W'(key[COORD_W +: HASH_W] * HASH_KY[HASH_W-1:0]);
        hz = HASH_W'(key[2*COORD_W +: HASH_W] * HASH_KZ[HASH_W-1:0]);
        return hx ^ hy ^ hz;
    endfunction

endpackage
`default_nettype wire

// ----- rtl/rgvd_ctrl.sv -----
`default_nettype none
// ---------------------------------------------------------------------------
// rgvd_ctrl
// Sequencer: clearing pass, arithmetic steps, gate decision, hash probing.
// ---------------------------------------------------------------------------
module rgvd_ctrl (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                in_valid,
    output logic                     ready,
    input  wire rgvd_pkg::rgvd_sts_t sts,
    output rgvd_pkg::rgvd_cmd_t      cmd
);

    typedef enum logic [6:0] {
        ST_IDLE  = 7'b0000001,
        ST_CLEAR = 7'b0000010,
        ST_CALC  = 7'b0000100,
        ST_CHECK = 7'b0001000,
        ST_READ  = 7'b0010000,
        ST_CMP   = 7'b0100000,
        ST_EMIT  = 7'b1000000
    } state_t;

    state_t                          state_reg, state_next;
    logic [rgvd_pkg::STEP_W-1:0]     step_reg, step_next;
    logic [rgvd_pkg::HASH_W-1:0]     clr_reg, clr_next;
    logic                            pend_reg, pend_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
            step_reg  <= '0;
            clr_reg   <= '0;
            pend_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            step_reg  <= step_next;
            clr_reg   <= clr_next;
            pend_reg  <= pend_next;
        end
    end

    assign ready = (state_reg == ST_IDLE);

    always_comb
    begin
        state_next   = state_reg;
        step_next    = step_reg;
        clr_next     = clr_reg;
        pend_next    = pend_reg;
        cmd          = '0;
        cmd.step_idx = step_reg;
        cmd.clr_addr = clr_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load  = 1'b1;
                    step_next = '0;
                    if (sts.scan_start && sts.epoch_wrap)
                    begin
                        pend_next  = 1'b1;
                        clr_next   = '0;
                        state_next = ST_CLEAR;
                    end
                    else
                    begin
                        state_next = ST_CALC;
                    end
                end
            end
            ST_CLEAR:
            begin
                cmd.clr_wr = 1'b1;
                clr_next   = clr_reg + 1'b1;
                if (clr_reg == '1)
                begin
                    pend_next  = 1'b0;
                    state_next = pend_reg ? ST_CALC : ST_IDLE;
                end
            end
            ST_CALC:
            begin
                cmd.step  = 1'b1;
                step_next = step_reg + 1'b1;
                if (step_reg == rgvd_pkg::STEP_W'(rgvd_pkg::DIV_STEPS - 1))
                begin
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK:
            begin
                if (!sts.keep_ok)
                begin
                    state_next = ST_IDLE;
                end
                else if (sts.leaf_zero)
                begin
                    state_next = ST_EMIT;
                end
                else
                begin
                    cmd.probe_init = 1'b1;
                    state_next     = ST_READ;
                end
            end
            ST_READ:
            begin
                cmd.rd     = 1'b1;
                state_next = ST_CMP;
            end
            ST_CMP:
            begin
                if (sts.slot_hit)
                begin
                    state_next = ST_IDLE;
                end
                else if (sts.slot_empty)
                begin
                    cmd.ins    = 1'b1;
                    state_next = ST_EMIT;
                end
                else
                begin
                    cmd.probe_adv = 1'b1;
                    state_next    = ST_READ;
                end
            end
            ST_EMIT:
            begin
                if (!sts.out_busy)
                begin
                    cmd.emit   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule
`default_nettype wire

// ----- rtl/rgvd_datapath.sv -----
`default_nettype none
// ---------------------------------------------------------------------------
// rgvd_datapath
// Registers, shared squarer, three serial dividers, voxel slot memory.
// ---------------------------------------------------------------------------
module rgvd_datapath (
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    input  wire logic                                 cfg_we,
    input  wire logic [rgvd_pkg::CFG_IDX_W-1:0]       cfg_idx,
    input  wire logic [rgvd_pkg::CFG_DATA_W-1:0]      cfg_data,
    input  wire rgvd_pkg::in_item_t                   in_item,
    output logic                                      out_valid,
    input  wire logic                                 out_stall,
    output rgvd_pkg::out_item_t                       out_item,
    input  wire rgvd_pkg::rgvd_cmd_t                  cmd,
    output rgvd_pkg::rgvd_sts_t                       sts
);

    localparam int CW = rgvd_pkg::COORD_W;
    localparam int LW = rgvd_pkg::LEAF_W;
    localparam int MW = rgvd_pkg::EPOCH_W + rgvd_pkg::KEY_W;

    // configuration
    logic [rgvd_pkg::RANGE_W-1:0] min_reg, max_reg, blind_reg;
    logic [LW-1:0]                leaf_reg;
    logic [rgvd_pkg::LIMIT_W-1:0] maxpts_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_reg    <= '0;
            max_reg    <= '1;
            blind_reg  <= '0;
            leaf_reg   <= '0;
            maxpts_reg <= rgvd_pkg::LIMIT_W'(rgvd_pkg::MAX_POINTS);
        end
        else if (cfg_we)
        begin
            case (cfg_idx)
                rgvd_pkg::REG_MIN_RANGE: min_reg    <= cfg_data;
                rgvd_pkg::REG_MAX_RANGE: max_reg    <= cfg_data;
                rgvd_pkg::REG_BLIND:     blind_reg  <= cfg_data;
                rgvd_pkg::REG_LEAF:      leaf_reg   <= cfg_data[LW-1:0];
                rgvd_pkg::REG_MAX_PTS:   maxpts_reg <= cfg_data[rgvd_pkg::LIMIT_W-1:0];
                default: ;
            endcase
        end
    end

    // control state
    logic [rgvd_pkg::LIMIT_W-1:0] kept_reg;
    logic [rgvd_pkg::EPOCH_W-1:0] epoch_reg;
    logic                         out_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            kept_reg      <= '0;
            epoch_reg     <= rgvd_pkg::EPOCH_FIRST;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.load && in_item.scan_start)
            begin
                kept_reg  <= '0;
                epoch_reg <= (epoch_reg == rgvd_pkg::EPOCH_LAST) ?
                             rgvd_pkg::EPOCH_FIRST : epoch_reg + 1'b1;
            end
            else if (cmd.emit)
            begin
                kept_reg <= kept_reg + 1'b1;
            end
            if (cmd.emit)
                out_valid_reg <= 1'b1;
            else if (!out_stall)
                out_valid_reg <= 1'b0;
        end
    end

    // point and squarer
    rgvd_pkg::in_item_t               pt_reg;
    logic signed [CW-1:0]             mul_a;
    logic [rgvd_pkg::SQ_W-1:0]        prod_reg;
    logic [rgvd_pkg::R2_W-1:0]        r2_reg;
    logic [rgvd_pkg::RSQ_W-1:0]       mn_reg, mx_reg, bl_reg;
    logic signed [2*CW-1:0]           mul_full;

    always_comb
    begin
        case (cmd.step_idx)
            rgvd_pkg::STEP_W'(0): mul_a = pt_reg.x_mm;
            rgvd_pkg::STEP_W'(1): mul_a = pt_reg.y_mm;
            rgvd_pkg::STEP_W'(2): mul_a = pt_reg.z_mm;
            rgvd_pkg::STEP_W'(3): mul_a = signed'({1'b0, min_reg});
            rgvd_pkg::STEP_W'(4): mul_a = signed'({1'b0, max_reg});
            default:              mul_a = signed'({1'b0, blind_reg});
        endcase
    end

    assign mul_full = mul_a * mul_a;

    // serial dividers
    logic [CW-1:0] dq_reg  [3];
    logic [LW:0]   rem_reg [3];
    logic [CW-1:0] mag     [3];
    logic [CW-1:0] key     [3];
    logic [LW:0]   rem_t   [3];

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            rem_t[i] = {rem_reg[i][LW-1:0], dq_reg[i][CW-1]};
        end
    end

    always_comb
    begin
        logic signed [CW-1:0] c [3];
        c[0] = in_item.x_mm;
        c[1] = in_item.y_mm;
        c[2] = in_item.z_mm;
        for (int i = 0; i < 3; i++)
        begin
            mag[i] = c[i][CW-1] ? CW'(-c[i]) : c[i];
        end
    end

    always_comb
    begin
        logic neg [3];
        neg[0] = pt_reg.x_mm[CW-1];
        neg[1] = pt_reg.y_mm[CW-1];
        neg[2] = pt_reg.z_mm[CW-1];
        for (int i = 0; i < 3; i++)
        begin
            if (!neg[i])
                key[i] = dq_reg[i];
            else if (rem_reg[i] != '0)
                key[i] = ~dq_reg[i];
            else
                key[i] = CW'(-dq_reg[i]);
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            pt_reg <= in_item;
            r2_reg <= '0;
            for (int i = 0; i < 3; i++)
            begin
                dq_reg[i]  <= mag[i];
                rem_reg[i] <= '0;
            end
        end
        else if (cmd.step)
        begin
            prod_reg <= mul_full[rgvd_pkg::SQ_W-1:0];
            case (cmd.step_idx)
                rgvd_pkg::STEP_W'(1),
                rgvd_pkg::STEP_W'(2),
                rgvd_pkg::STEP_W'(3): r2_reg <= r2_reg + rgvd_pkg::R2_W'(prod_reg);
                rgvd_pkg::STEP_W'(4): mn_reg <= prod_reg[rgvd_pkg::RSQ_W-1:0];
                rgvd_pkg::STEP_W'(5): mx_reg <= prod_reg[rgvd_pkg::RSQ_W-1:0];
                rgvd_pkg::STEP_W'(6): bl_reg <= prod_reg[rgvd_pkg::RSQ_W-1:0];
                default: ;
            endcase
            for (int i = 0; i < 3; i++)
            begin
                if (rem_t[i] >= {1'b0, leaf_reg})
                begin
                    rem_reg[i] <= rem_t[i] - {1'b0, leaf_reg};
                    dq_reg[i]  <= {dq_reg[i][CW-2:0], 1'b1};
                end
                else
                begin
                    rem_reg[i] <= rem_t[i];
                    dq_reg[i]  <= {dq_reg[i][CW-2:0], 1'b0};
                end
            end
        end
    end

    // gate
    logic [rgvd_pkg::LIMIT_W-1:0] limit;
    logic                         range_ok;

    assign limit = (maxpts_reg > rgvd_pkg::LIMIT_W'(rgvd_pkg::MAX_POINTS)) ?
                   rgvd_pkg::LIMIT_W'(rgvd_pkg::MAX_POINTS) : maxpts_reg;
    assign range_ok = !(r2_reg < rgvd_pkg::R2_W'(mn_reg)) &&
                      !(r2_reg > rgvd_pkg::R2_W'(mx_reg)) &&
                      !(r2_reg < rgvd_pkg::R2_W'(bl_reg));

    // voxel slots: {epoch, key}; an entry from another epoch is empty
    logic [MW-1:0]                mem [rgvd_pkg::HASH_SLOTS];
    logic [MW-1:0]                rd_reg;
    logic [rgvd_pkg::KEY_W-1:0]   key_reg;
    logic [rgvd_pkg::KEY_W-1:0]   key_cat;
    logic [rgvd_pkg::HASH_W-1:0]  addr_reg;

    assign key_cat = {key[2], key[1], key[0]};

    always_ff @(posedge clk)
    begin
        if (cmd.probe_init)
        begin
            key_reg  <= key_cat;
            addr_reg <= rgvd_pkg::slot_hash(key_cat);
        end
        else if (cmd.probe_adv)
        begin
            addr_reg <= addr_reg + 1'b1;
        end
        if (cmd.rd)
            rd_reg <= mem[addr_reg];
        if (cmd.clr_wr)
            mem[cmd.clr_addr] <= {rgvd_pkg::EPOCH_EMPTY, {rgvd_pkg::KEY_W{1'b0}}};
        else if (cmd.ins)
            mem[addr_reg] <= {epoch_reg, key_reg};
    end

    // output register
    always_ff @(posedge clk)
    begin
        if (cmd.emit)
        begin
            out_item.out_x_mm     <= pt_reg.x_mm;
            out_item.out_y_mm     <= pt_reg.y_mm;
            out_item.out_z_mm     <= pt_reg.z_mm;
            out_item.out_time_tag <= pt_reg.time_tag;
        end
    end

    assign out_valid = out_valid_reg;

    always_comb
    begin
        sts.scan_start = in_item.scan_start;
        sts.epoch_wrap = (epoch_reg == rgvd_pkg::EPOCH_LAST);
        sts.keep_ok    = range_ok && (kept_reg < limit);
        sts.leaf_zero  = (leaf_reg == '0);
        sts.slot_empty = (rd_reg[MW-1 -: rgvd_pkg::EPOCH_W] != epoch_reg);
        sts.slot_hit   = !sts.slot_empty && (rd_reg[rgvd_pkg::KEY_W-1:0] == key_reg);
        sts.out_busy   = out_valid_reg && out_stall;
    end

endmodule
`default_nettype wire

// ----- rtl/range_gate_voxel_dedup_filter.sv -----
`default_nettype none
// ---------------------------------------------------------------------------
// range_gate_voxel_dedup_filter
// Lidar point range gate with first-point-per-voxel downsampling.
// ---------------------------------------------------------------------------
// One point at a time. Acceptance in idle is followed by 20 restoring
// divider steps (shared with the six squarings) and the gate decision,
// where a dropped point ends. With a voxel leaf set, each slot probe reads
// a slot of the voxel memory and compares it: a hit drops the point, an
// empty slot takes its key and the point goes to the result register; with
// the leaf at zero no probe is made. A stalled output holds the point back.
// After reset, and on every 255th scan start, a clearing pass over all 8192
// slots runs with the input stalled; configuration writes are taken at any time.
module range_gate_voxel_dedup_filter (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            in_valid,
    output logic                                 in_stall,
    input  wire rgvd_pkg::in_item_t              in_item,
    output logic                                 out_valid,
    input  wire logic                            out_stall,
    output rgvd_pkg::out_item_t                  out_item,
    input  wire logic                            cfg_we,
    input  wire logic [rgvd_pkg::CFG_IDX_W-1:0]  cfg_idx,
    input  wire logic [rgvd_pkg::CFG_DATA_W-1:0] cfg_data
);

    rgvd_pkg::rgvd_cmd_t cmd;
    rgvd_pkg::rgvd_sts_t sts;
    logic                ready;

    assign in_stall = !ready;

    rgvd_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .ready    (ready),
        .sts      (sts),
        .cmd      (cmd)
    );

    rgvd_datapath u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_idx   (cfg_idx),
        .cfg_data  (cfg_data),
        .in_item   (in_item),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_item  (out_item),
        .cmd       (cmd),
        .sts       (sts)
    );

endmodule
`default_nettype wire

// ----- tb/range_gate_voxel_dedup_filter_test.sv -----
// ---------------------------------------------------------------------------
// range_gate_voxel_dedup_filter_test
// Drives lidar points through the range gate voxel filter under random
// idling, predicts the kept points from a local copy of the voxel set and
// kept count, and checks each result item field by field.
// ---------------------------------------------------------------------------
module range_gate_voxel_dedup_filter_test;

    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [rgvd_pkg::CFG_IDX_W-1:0] REG_SPARE = rgvd_pkg::CFG_IDX_W'(7);
    localparam int SETTLE_CYCLES = 300;

    logic                            clk;
    logic                            rst_n;
    logic                            in_valid;
    logic                            in_stall;
    rgvd_pkg::in_item_t              in_item;
    logic                            out_valid;
    logic                            out_stall;
    rgvd_pkg::out_item_t             out_item;
    logic                            cfg_we;
    logic [rgvd_pkg::CFG_IDX_W-1:0]  cfg_idx;
    logic [rgvd_pkg::CFG_DATA_W-1:0] cfg_data;

    range_gate_voxel_dedup_filter u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_item   (in_item),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_item  (out_item),
        .cfg_we    (cfg_we),
        .cfg_idx   (cfg_idx),
        .cfg_data  (cfg_data)
    );

    rgvd_pkg::in_item_t  point_queue[$];
    rgvd_pkg::out_item_t kept_points[$];
    logic [60:0]         voxel_set[rgvd_pkg::HASH_SLOTS];
    int unsigned         kept_in_scan;
    int unsigned         gate_lo_mm;
    int unsigned         gate_hi_mm;
    int unsigned         blind_radius;
    int unsigned         leaf;
    int unsigned         point_limit;
    int                  errors;
    bit                  quiet;
    int                  gap_left;
    int                  stall_left;

    function automatic longint floor_quot(longint a, longint d);
        longint q;
        q = a / d;
        if ((a % d) != 0 && a < 0)
            q = q - 1;
        return q;
    endfunction

    function automatic bit voxel_is_new(logic [59:0] key);
        logic [60:0] slot_word;
        int unsigned h;
        int unsigned slot;
        slot_word = {1'b1, key};
        h = (int'(key[19:0]) * 32'd73856093) ^ (int'(key[39:20]) * 32'd19349663)
            ^ (int'(key[59:40]) * 32'd83492791);
        slot = h % rgvd_pkg::HASH_SLOTS;
        for (int n = 0; n < rgvd_pkg::HASH_SLOTS; n++)
        begin
            if (voxel_set[slot] == slot_word)
                return 1'b0;
            if (!voxel_set[slot][60])
            begin
                voxel_set[slot] = slot_word;
                return 1'b1;
            end
            slot = (slot + 1) % rgvd_pkg::HASH_SLOTS;
        end
        return 1'b0;
    endfunction

    function automatic void predict_point(rgvd_pkg::in_item_t it);
        longint              x;
        longint              y;
        longint              z;
        longint              r2;
        int unsigned         lim;
        logic [59:0]         key;
        rgvd_pkg::out_item_t res;
        x = it.x_mm;
        y = it.y_mm;
        z = it.z_mm;
        if (it.scan_start)
        begin
            foreach (voxel_set[i])
                voxel_set[i] = '0;
            kept_in_scan = 0;
        end
        r2 = x * x + y * y + z * z;
        if (r2 < longint'(gate_lo_mm) * gate_lo_mm || r2 > longint'(gate_hi_mm) * gate_hi_mm
            || r2 < longint'(blind_radius) * blind_radius)
            return;
        lim = (point_limit > rgvd_pkg::MAX_POINTS) ? rgvd_pkg::MAX_POINTS : point_limit;
        if (kept_in_scan >= lim)
            return;
        if (leaf != 0)
        begin
            key[19:0]  = 20'(floor_quot(x, leaf));
            key[39:20] = 20'(floor_quot(y, leaf));
            key[59:40] = 20'(floor_quot(z, leaf));
            if (!voxel_is_new(key))
                return;
        end
        kept_in_scan++;
        res.out_x_mm     = it.x_mm;
        res.out_y_mm     = it.y_mm;
        res.out_z_mm     = it.z_mm;
        res.out_time_tag = it.time_tag;
        kept_points = {kept_points, res};
    endfunction

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // register mirror
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            gate_lo_mm   = 0;
            gate_hi_mm   = 524287;
            blind_radius = 0;
            leaf         = 0;
            point_limit  = 4096;
        end
        else if (cfg_we)
        begin
            case (cfg_idx)
                rgvd_pkg::REG_MIN_RANGE: gate_lo_mm   = cfg_data;
                rgvd_pkg::REG_MAX_RANGE: gate_hi_mm   = cfg_data;
                rgvd_pkg::REG_BLIND:     blind_radius = cfg_data;
                rgvd_pkg::REG_LEAF:      leaf         = cfg_data[rgvd_pkg::LEAF_W-1:0];
                rgvd_pkg::REG_MAX_PTS:   point_limit  = cfg_data[rgvd_pkg::LIMIT_W-1:0];
                default: ;
            endcase
        end
    end

    // driver
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            gap_left = 0;
        end
        else
        begin
            if (in_valid && !in_stall)
            begin
                predict_point(in_item);
                if (!quiet && $urandom_range(0, 3) == 0)
                    gap_left = $urandom_range(1, 8);
            end
            if (!(in_valid && in_stall))
            begin
                if (gap_left > 0 && !quiet)
                begin
                    gap_left--;
                    in_valid <= 1'b0;
                end
                else if (point_queue.size() > 0)
                begin
                    in_item  <= point_queue.pop_front();
                    in_valid <= 1'b1;
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // monitor
    always @(posedge clk)
    begin
        rgvd_pkg::out_item_t want;
        if (!rst_n)
        begin
            out_stall <= 1'b0;
            stall_left = 0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (kept_points.size() == 0)
                begin
                    $display("%t unexpected item: actual %h", $realtime, out_item);
                    errors++;
                end
                else
                begin
                    want = kept_points.pop_front();
                    if (out_item.out_x_mm !== want.out_x_mm
                        || out_item.out_y_mm !== want.out_y_mm
                        || out_item.out_z_mm !== want.out_z_mm
                        || out_item.out_time_tag !== want.out_time_tag)
                    begin
                        $display("%t mismatch: expected %h actual %h",
                                 $realtime, want, out_item);
                        errors++;
                    end
                end
            end
            if (stall_left > 0 && !quiet)
            begin
                stall_left--;
                out_stall <= 1'b1;
            end
            else
            begin
                if (!quiet && $urandom_range(0, 5) == 0)
                    stall_left = $urandom_range(0, 7);
                out_stall <= (!quiet && stall_left > 0);
            end
        end
    end

    task automatic add_point(bit ss, int x, int y, int z, int t);
        rgvd_pkg::in_item_t it;
        it.scan_start = ss;
        it.x_mm       = rgvd_pkg::COORD_W'(x);
        it.y_mm       = rgvd_pkg::COORD_W'(y);
        it.z_mm       = rgvd_pkg::COORD_W'(z);
        it.time_tag   = rgvd_pkg::TAG_W'(t);
        point_queue = {point_queue, it};
    endtask

    task automatic write_reg(logic [rgvd_pkg::CFG_IDX_W-1:0] idx, int unsigned value);
        @(posedge clk);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= rgvd_pkg::CFG_DATA_W'(value);
        @(posedge clk);
        cfg_we   <= 1'b0;
    endtask

    // wait until the block is idle again, a clearing pass included
    task automatic drain;
        wait (point_queue.size() == 0 && !in_valid && kept_points.size() == 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
        while (in_stall)
            @(posedge clk);
    endtask

    task automatic configure(int unsigned mn, int unsigned mx, int unsigned bl,
                             int unsigned lf, int unsigned lim);
        write_reg(rgvd_pkg::REG_MIN_RANGE, mn);
        write_reg(rgvd_pkg::REG_MAX_RANGE, mx);
        write_reg(rgvd_pkg::REG_BLIND, bl);
        write_reg(rgvd_pkg::REG_LEAF, lf);
        write_reg(rgvd_pkg::REG_MAX_PTS, lim);
    endtask

    task automatic random_points(int count, int spread);
        int c;
        for (int i = 0; i < count; i++)
        begin
            c = $urandom_range(0, 9);
            if (c == 0)
                add_point($urandom_range(0, 1), $urandom, $urandom, $urandom, $urandom);
            else
                add_point($urandom_range(0, 5) == 0,
                          $urandom_range(0, 2 * spread) - spread,
                          $urandom_range(0, 2 * spread) - spread,
                          $urandom_range(0, 2 * spread) - spread, $urandom);
        end
    endtask

    initial
    begin
        int unsigned mn;
        int unsigned mx;
        int unsigned lf;
        int unsigned lim;
        rst_n     = 1'b0;
        in_valid  = 1'b0;
        in_item   = '0;
        out_stall = 1'b0;
        cfg_we    = 1'b0;
        cfg_idx   = '0;
        cfg_data  = '0;
        errors    = 0;
        quiet     = 1'b0;
        kept_in_scan = 0;
        foreach (voxel_set[i])
            voxel_set[i] = '0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        // reset values: leaf off, full range
        add_point(1, 0, 0, 0, 0);
        add_point(0, -524288, -524288, -524288, 16'hffff);
        add_point(0, 524287, 0, 0, 16'hffff);
        add_point(0, -524288, 0, 0, 1);
        add_point(0, 0, -524287, 0, 2);
        add_point(0, 0, 0, 0, 3);
        add_point(0, 0, 0, 524287, 4);
        drain();

        // gate edges, floor division across zero, duplicates
        configure(100, 1000, 200, 10, 8191);
        write_reg(REG_SPARE, 0);
        add_point(1, 199, 0, 0, 10);
        add_point(0, 200, 0, 0, 11);
        add_point(0, 205, 0, 0, 12);
        add_point(0, 0, 1000, 0, 13);
        add_point(0, 0, 1001, 0, 14);
        add_point(0, -1, 0, -300, 15);
        add_point(0, 1, 0, -300, 16);
        add_point(0, -10, 0, -300, 17);
        add_point(1, 205, 0, 0, 18);
        drain();

        configure(600, 500, 0, 1, 3);
        add_point(1, 550, 0, 0, 20);
        drain();
        configure(0, 524287, 0, 1, 0);
        add_point(1, 5, 5, 5, 21);
        drain();
        write_reg(rgvd_pkg::REG_LEAF, 0);
        add_point(0, 5, 5, 5, 22);
        drain();
        configure(0, 524287, 0, 0, 3);
        for (int i = 0; i < 5; i++)
            add_point(i == 0, i, i, i, 30 + i);
        drain();

        for (int p = 0; p < 12; p++)
        begin
            case ($urandom_range(0, 4))
                0: lf = 0;
                1: lf = 1;
                2: lf = 65535;
                default: lf = $urandom_range(2, 800);
            endcase
            case ($urandom_range(0, 3))
                0: lim = 0;
                1: lim = 8191;
                2: lim = $urandom_range(1, 10);
                default: lim = 4096;
            endcase
            mn = ($urandom_range(0, 2) == 0) ? $urandom_range(0, 3000) : 0;
            mx = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 6000) : 524287;
            configure(mn, mx, $urandom_range(0, 1) ? $urandom_range(0, 1500) : 0, lf, lim);
            if (p == 11)
            begin
                drain();
                quiet = 1'b1;
            end
            random_points(110, (p % 3 == 0) ? 524287 : 4000);
            drain();
        end

        if (errors == 0)
            $display("[range_gate_voxel_dedup_filter] OK");
        else
            $display("[range_gate_voxel_dedup_filter] ERROR");
        $finish;
    end

    initial
    begin
        #8ms;
        $display("[range_gate_voxel_dedup_filter] ERROR");
        $finish;
    end

endmodule

// ----- sim.f -----
rtl/rgvd_pkg.sv
rtl/rgvd_ctrl.sv
rtl/rgvd_datapath.sv
rtl/range_gate_voxel_dedup_filter.sv
tb/range_gate_voxel_dedup_filter_test.sv
